@@ sv/leader_election_role_fsm_unit_assert.svh @@
// Assertion macros shared by the leader election role controller RTL.
`ifndef LEADER_ELECTION_ROLE_FSM_UNIT_ASSERT_SVH
`define LEADER_ELECTION_ROLE_FSM_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define LER_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled while in reset.
`define LER_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle implication violated");

`endif

@@ sv/ler_pkg.sv @@
// Package: types, codes and constants of the leader election role controller.
package ler_pkg;

    localparam int ID_BITS    = 22;
    localparam int COUNT_BITS = 16;

    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_OWN_ID           = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_AS_LEADER  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEARTBEAT_PERIOD = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FOLLOWER_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ELECTION_WINDOW  = 3'd4;

    localparam int HEARTBEAT_PERIOD_RST = 5;
    localparam int FOLLOWER_TIMEOUT_RST = 7;
    localparam int ELECTION_WINDOW_RST  = 2;

    typedef enum logic [2:0] {
        R_IDLE      = 3'd0,
        R_LEADER    = 3'd1,
        R_FOLLOWER  = 3'd2,
        R_CALLED    = 3'd3,
        R_CANDIDATE = 3'd4,
        R_AWAIT     = 3'd5
    } role_t;

    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_HEART = 3'd1,
        K_ELECT = 3'd2,
        K_CAND  = 3'd3,
        K_NEWL  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_START  = 3'd1,
        OP_HEART  = 3'd2,
        OP_ELECT  = 3'd3,
        OP_CAND   = 3'd4,
        OP_LEADER = 3'd5
    } op_t;

    // Core to result buffer: load strobe and message count.
    typedef struct packed {
        logic load;
        logic two;
    } pair_ctl_t;

endpackage

@@ sv/ler_if.sv @@
// Event and message channel interfaces of the leader election role controller.
interface ler_in_if #(
    parameter int ID_BITS = ler_pkg::ID_BITS
);
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [ID_BITS-1:0] peer_id;

    modport source (output valid, output operation, output peer_id, input ready);
    modport sink   (input valid, input operation, input peer_id, output ready);
endinterface

interface ler_out_if #(
    parameter int ID_BITS = ler_pkg::ID_BITS
);
    logic               valid;
    logic               ready;
    logic [2:0]         send_kind;
    logic [ID_BITS-1:0] send_id;
    logic [2:0]         role_now;
    logic               last_of_run;

    modport source (output valid, output send_kind, output send_id, output role_now,
                    output last_of_run, input ready);
    modport sink   (input valid, input send_kind, input send_id, input role_now,
                    input last_of_run, output ready);
endinterface

@@ sv/ler_core.sv @@
// Input register, role state and next-state logic of the election controller.
module ler_core #(
    parameter int ID_BITS    = ler_pkg::ID_BITS,
    parameter int COUNT_BITS = ler_pkg::COUNT_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            in_op,
    input  logic [ID_BITS-1:0]    in_peer,
    input  logic [ID_BITS-1:0]    own_id,
    input  logic                  start_as_leader,
    input  logic [COUNT_BITS-1:0] heartbeat_period,
    input  logic [COUNT_BITS-1:0] follower_timeout,
    input  logic [COUNT_BITS-1:0] election_window,
    input  logic                  buf_free,
    output ler_pkg::pair_ctl_t    ctl,
    output ler_pkg::kind_t        msg_kind [2],
    output logic [ID_BITS-1:0]    msg_id [2],
    output ler_pkg::role_t        role_new
);

`include "leader_election_role_fsm_unit_assert.svh"

    function automatic logic [COUNT_BITS-1:0] load_count(input logic [COUNT_BITS-1:0] v);
        return (v == '0) ? COUNT_BITS'(1) : v;
    endfunction

    // input register
    logic               s1_valid_reg;
    ler_pkg::op_t       op_reg;
    logic [ID_BITS-1:0] peer_reg;
    logic               take;

    // role state
    ler_pkg::role_t        role_reg, role_next;
    logic [COUNT_BITS-1:0] hc_reg, hc_next;
    logic                  ha_reg, ha_next;
    logic [COUNT_BITS-1:0] wc_reg, wc_next;
    logic [ID_BITS-1:0]    best_reg, best_next;
    logic                  bv_reg, bv_next;

    logic [COUNT_BITS-1:0] hc_dec;
    logic [COUNT_BITS-1:0] wc_dec;
    logic                  hb_fire;
    ler_pkg::kind_t        hb_kind;
    logic                  win_own;
    logic                  two;

    assign take     = s1_valid_reg && buf_free;
    assign in_ready = !s1_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= ler_pkg::op_t'(in_op);
            peer_reg <= in_peer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg <= ler_pkg::R_IDLE;
            hc_reg   <= '0;
            ha_reg   <= 1'b0;
            wc_reg   <= '0;
            best_reg <= '0;
            bv_reg   <= 1'b0;
        end
        else if (take)
        begin
            role_reg <= role_next;
            hc_reg   <= hc_next;
            ha_reg   <= ha_next;
            wc_reg   <= wc_next;
            best_reg <= best_next;
            bv_reg   <= bv_next;
        end
    end

    always_comb
    begin
        role_next   = role_reg;
        hc_next     = hc_reg;
        ha_next     = ha_reg;
        wc_next     = wc_reg;
        best_next   = best_reg;
        bv_next     = bv_reg;
        hc_dec      = hc_reg - COUNT_BITS'(1);
        wc_dec      = wc_reg - COUNT_BITS'(1);
        hb_fire     = 1'b0;
        hb_kind     = ler_pkg::K_NONE;
        win_own     = 1'b0;
        two         = 1'b0;
        msg_kind[0] = ler_pkg::K_NONE;
        msg_kind[1] = ler_pkg::K_NONE;
        msg_id[0]   = '0;
        msg_id[1]   = '0;

        if (op_reg == ler_pkg::OP_START)
        begin
            hc_next   = '0;
            ha_next   = 1'b0;
            wc_next   = '0;
            best_next = '0;
            bv_next   = 1'b0;
            if (start_as_leader)
            begin
                role_next   = ler_pkg::R_CALLED;
                msg_kind[0] = ler_pkg::K_ELECT;
                msg_id[0]   = own_id;
            end
            else
            begin
                role_next = ler_pkg::R_FOLLOWER;
                hc_next   = load_count(follower_timeout);
                ha_next   = 1'b1;
            end
        end
        else if (role_reg != ler_pkg::R_IDLE)
        begin
            case (op_reg)
                ler_pkg::OP_TICK:
                begin
                    if (ha_reg)
                    begin
                        hc_next = hc_dec;
                        if (hc_dec == '0)
                        begin
                            case (role_reg)
                                ler_pkg::R_LEADER:
                                begin
                                    hb_fire = 1'b1;
                                    hb_kind = ler_pkg::K_HEART;
                                    hc_next = load_count(heartbeat_period);
                                end
                                ler_pkg::R_FOLLOWER:
                                begin
                                    hb_fire   = 1'b1;
                                    hb_kind   = ler_pkg::K_ELECT;
                                    ha_next   = 1'b0;
                                    role_next = ler_pkg::R_CALLED;
                                end
                                default:
                                begin
                                    ha_next = 1'b0;
                                end
                            endcase
                        end
                    end
                    // window close decides the election
                    if (wc_reg != '0)
                    begin
                        wc_next = wc_dec;
                        if (wc_dec == '0 && role_next == ler_pkg::R_CANDIDATE)
                        begin
                            best_next = '0;
                            bv_next   = 1'b0;
                            if (bv_reg && best_reg > own_id)
                            begin
                                role_next = ler_pkg::R_AWAIT;
                            end
                            else
                            begin
                                win_own   = 1'b1;
                                role_next = ler_pkg::R_LEADER;
                                hc_next   = load_count(heartbeat_period);
                                ha_next   = 1'b1;
                            end
                        end
                    end
                    // at most two messages; a timer message goes first
                    if (hb_fire)
                    begin
                        msg_kind[0] = hb_kind;
                        if (win_own)
                        begin
                            msg_kind[1] = ler_pkg::K_NEWL;
                            msg_id[1]   = own_id;
                            two         = 1'b1;
                        end
                    end
                    else if (win_own)
                    begin
                        msg_kind[0] = ler_pkg::K_NEWL;
                        msg_id[0]   = own_id;
                        msg_kind[1] = ler_pkg::K_HEART;
                        two         = 1'b1;
                    end
                end
                ler_pkg::OP_HEART:
                begin
                    if (role_reg == ler_pkg::R_FOLLOWER)
                    begin
                        hc_next = load_count(follower_timeout);
                    end
                end
                ler_pkg::OP_ELECT:
                begin
                    if (role_reg == ler_pkg::R_LEADER || role_reg == ler_pkg::R_FOLLOWER)
                    begin
                        ha_next = 1'b0;
                        hc_next = '0;
                    end
                    role_next   = ler_pkg::R_CANDIDATE;
                    msg_kind[0] = ler_pkg::K_CAND;
                    msg_id[0]   = own_id;
                    wc_next     = load_count(election_window);
                end
                ler_pkg::OP_CAND:
                begin
                    if (role_reg == ler_pkg::R_CANDIDATE)
                    begin
                        if (!bv_reg || peer_reg > best_reg)
                        begin
                            best_next = peer_reg;
                        end
                        bv_next = 1'b1;
                    end
                end
                ler_pkg::OP_LEADER:
                begin
                    if (role_reg == ler_pkg::R_AWAIT)
                    begin
                        role_next = ler_pkg::R_FOLLOWER;
                        hc_next   = load_count(follower_timeout);
                        ha_next   = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign ctl.load = take;
    assign ctl.two  = two;
    assign role_new = role_next;

    `LER_ASSERT_IMPL(a_idle_clear, clk, rst_n, role_reg == ler_pkg::R_IDLE,
        !ha_reg && wc_reg == '0 && !bv_reg)
    `LER_ASSERT_NEXT(a_start_leaves_idle, clk, rst_n, take && op_reg == ler_pkg::OP_START,
        role_reg != ler_pkg::R_IDLE)
    `LER_ASSERT_NEXT(a_pair_means_leader, clk, rst_n, ctl.load && ctl.two,
        role_reg == ler_pkg::R_LEADER)

endmodule

@@ sv/ler_outbuf.sv @@
// Two-slot result buffer: holds one event's messages and sends them in order.
module ler_outbuf #(
    parameter int ID_BITS = ler_pkg::ID_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ler_pkg::pair_ctl_t ctl,
    input  ler_pkg::kind_t     msg_kind [2],
    input  logic [ID_BITS-1:0] msg_id [2],
    input  ler_pkg::role_t     role_new,
    output logic               buf_free,
    ler_out_if.source          msg
);

`include "leader_election_role_fsm_unit_assert.svh"

    ler_pkg::kind_t     kind_reg [2];
    logic [ID_BITS-1:0] id_reg [2];
    ler_pkg::role_t     role_reg;
    logic [1:0]         cnt_reg, cnt_next;
    logic               head_reg, head_next;
    logic               fire;

    assign msg.valid       = (cnt_reg != 2'd0);
    assign fire            = msg.valid && msg.ready;
    assign buf_free        = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && fire);
    assign msg.send_kind   = kind_reg[head_reg];
    assign msg.send_id     = id_reg[head_reg];
    assign msg.role_now    = role_reg;
    assign msg.last_of_run = (cnt_reg == 2'd1);

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        if (ctl.load)
        begin
            cnt_next  = ctl.two ? 2'd2 : 2'd1;
            head_next = 1'b0;
        end
        else if (fire)
        begin
            cnt_next  = cnt_reg - 2'd1;
            head_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            head_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            kind_reg[0] <= msg_kind[0];
            kind_reg[1] <= msg_kind[1];
            id_reg[0]   <= msg_id[0];
            id_reg[1]   <= msg_id[1];
            role_reg    <= role_new;
        end
    end

    `LER_ASSERT_IMPL(a_load_room, clk, rst_n, ctl.load, buf_free)
    `LER_ASSERT_IMPL(a_pair_head, clk, rst_n, cnt_reg == 2'd2, !head_reg)
    `LER_ASSERT_NEXT(a_pair_drain, clk, rst_n, cnt_reg == 2'd2 && fire,
        cnt_reg == 2'd1 && head_reg)

endmodule

@@ sv/leader_election_role_fsm_unit.sv @@
// An event is registered at acceptance and loaded into the result buffer once the buffer is free.
// Throughput: one event per cycle when each event yields one message and msg.ready stays high;
// an event that wins an election yields two messages, sent one at a time on the single output
// port. The two-slot result buffer and the input register set this rate.
// Reset (rst_n, async, active low): role idle, countdowns stopped, no candidate seen,
// registers own_id 0, start_as_leader 0, period 5, timeout 7, window 2.
module leader_election_role_fsm_unit #(
    parameter int ID_BITS    = ler_pkg::ID_BITS,
    parameter int COUNT_BITS = ler_pkg::COUNT_BITS,
    localparam int CFG_W     = (ID_BITS > COUNT_BITS) ? ID_BITS : COUNT_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port; the user must write it only while idle, the block does not enforce this
    input  logic                             cfg_we,
    input  logic [ler_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_W-1:0]                 cfg_data,
    // event transactions in, message transactions out
    ler_in_if.sink                           ev,
    ler_out_if.source                        msg
);

    // configuration registers
    logic [ID_BITS-1:0]    own_id_reg;
    logic                  start_as_leader_reg;
    logic [COUNT_BITS-1:0] heartbeat_period_reg;
    logic [COUNT_BITS-1:0] follower_timeout_reg;
    logic [COUNT_BITS-1:0] election_window_reg;

    // core to buffer
    ler_pkg::pair_ctl_t    ctl;
    ler_pkg::kind_t        msg_kind [2];
    logic [ID_BITS-1:0]    msg_id [2];
    ler_pkg::role_t        role_new;
    logic                  buf_free;

    // writes to indexes past the last register are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg           <= '0;
            start_as_leader_reg  <= 1'b0;
            heartbeat_period_reg <= COUNT_BITS'(ler_pkg::HEARTBEAT_PERIOD_RST);
            follower_timeout_reg <= COUNT_BITS'(ler_pkg::FOLLOWER_TIMEOUT_RST);
            election_window_reg  <= COUNT_BITS'(ler_pkg::ELECTION_WINDOW_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ler_pkg::CFG_OWN_ID:           own_id_reg           <= cfg_data[ID_BITS-1:0];
                ler_pkg::CFG_START_AS_LEADER:  start_as_leader_reg  <= cfg_data[0];
                ler_pkg::CFG_HEARTBEAT_PERIOD: heartbeat_period_reg <= cfg_data[COUNT_BITS-1:0];
                ler_pkg::CFG_FOLLOWER_TIMEOUT: follower_timeout_reg <= cfg_data[COUNT_BITS-1:0];
                ler_pkg::CFG_ELECTION_WINDOW:  election_window_reg  <= cfg_data[COUNT_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Core: holds the accepted event in its input register until the buffer is free, then updates role and
    // countdowns and hands up to two messages to the buffer in the same edge.
    ler_core #(
        .ID_BITS    (ID_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (ev.valid),
        .in_ready         (ev.ready),
        .in_op            (ev.operation),
        .in_peer          (ev.peer_id),
        .own_id           (own_id_reg),
        .start_as_leader  (start_as_leader_reg),
        .heartbeat_period (heartbeat_period_reg),
        .follower_timeout (follower_timeout_reg),
        .election_window  (election_window_reg),
        .buf_free         (buf_free),
        .ctl              (ctl),
        .msg_kind         (msg_kind),
        .msg_id           (msg_id),
        .role_new         (role_new)
    );

    // Buffer: sends the messages one transaction at a time, flags the last one,
    // and frees itself early so the next event can load as the last one leaves.
    ler_outbuf #(
        .ID_BITS (ID_BITS)
    ) u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .msg_kind (msg_kind),
        .msg_id   (msg_id),
        .role_new (role_new),
        .buf_free (buf_free),
        .msg      (msg)
    );

endmodule
